@@ rtl/sst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the sorted set table.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OP_W     = 2;
	localparam int ST_W     = 2;
	localparam int ECNT_W   = 5;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// broadcast to every cell
	typedef struct packed {
		logic                    ins_en;
		logic                    del_en;
		logic signed [KEY_W-1:0] key;
	} cmd_t;

	// compare flags a cell reports against the broadcast key
	typedef struct packed {
		logic gt;
		logic ge;
		logic eq;
	} cell_flags_t;

endpackage

@@ rtl/sst_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_cell
// One slot of the sorted chain: holds a key, compares it with the broadcast
// key and shifts from its left or right neighbor on insert or delete.
// ----------------------------------------------------------------------------
module sst_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sst_pkg::cmd_t                   cmd,
	input  logic                            valid,
	input  logic                            left_gt,
	input  logic signed [sst_pkg::KEY_W-1:0] left_key,
	input  logic signed [sst_pkg::KEY_W-1:0] right_key,
	output logic signed [sst_pkg::KEY_W-1:0] key,
	output sst_pkg::cell_flags_t            flags
);

	logic signed [sst_pkg::KEY_W-1:0] key_q;
	logic signed [sst_pkg::KEY_W-1:0] key_d;

	assign key      = key_q;
	assign flags.gt = valid && (key_q > cmd.key);
	assign flags.ge = valid && (key_q >= cmd.key);
	assign flags.eq = valid && (key_q == cmd.key);

	always_comb begin
		key_d = key_q;
		if (cmd.ins_en) begin
			// make room: larger keys move right, the new key lands at the gap
			if (left_gt) begin
				key_d = left_key;
			end else if (flags.gt || !valid) begin
				key_d = cmd.key;
			end
		end else if (cmd.del_en) begin
			// close the gap from the first match onward
			if (flags.ge) begin
				key_d = right_key;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else begin
			key_q <= key_d;
		end
	end

endmodule

@@ rtl/sorted_set_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_table_top
// Sorted table of up to CAPACITY signed keys with insert, delete and search.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis; each carries an opcode (insert, delete,
//   search) and a signed 32-bit key. Every input word yields exactly one
//   result word on m_axis with a status and the entry count after the
//   operation.
//   The keys sit in a chain of CAPACITY cells, one key per cell, kept in
//   ascending order. All cells compare against the key in the same cycle and
//   shift toward their neighbor on insert or delete together, however many
//   keys are held.
//   The result is valid in the cycle after input accept. Throughput: one
//   word per cycle while m_axis_tready is high.
//   A result waits in the output register while the receiver stalls; the
//   next input word is taken as soon as that register is being emptied.
//   Reset (arst_n low) empties the table; no clearing pass is needed.
//   Duplicates are kept, a new one after its equals; delete removes the
//   first match. Insert into a full table stores nothing.
// ----------------------------------------------------------------------------
module sorted_set_table_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [1:0] opcode, [33:2] key, [39:34] zero
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [1:0] status, [6:2] entry_count, [7] zero
);

	localparam int N = sst_pkg::CAPACITY;

	logic                               in_acc;
	sst_pkg::op_t                       op;
	logic signed [sst_pkg::KEY_W-1:0]   in_key;
	logic [sst_pkg::CNT_W-1:0]          count_q;
	logic [sst_pkg::CNT_W-1:0]          count_d;
	logic                               full;
	logic                               empty;
	logic                               found;
	sst_pkg::cmd_t                      cmd;
	sst_pkg::status_t                   status_d;
	logic                               out_valid_q;
	sst_pkg::status_t                   status_q;
	logic [sst_pkg::ECNT_W-1:0]         ecount_q;
	logic [sst_pkg::CNT_W+sst_pkg::ECNT_W-1:0] count_wide;

	logic signed [sst_pkg::KEY_W-1:0]   keys   [N];
	sst_pkg::cell_flags_t               flags  [N];
	logic [N-1:0]                       valid;
	logic [N-1:0]                       eq_vec;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign op            = sst_pkg::op_t'(s_axis_tdata[1:0]);
	assign in_key        = s_axis_tdata[33:2];

	assign full  = (count_q == sst_pkg::CNT_W'(N));
	assign empty = (count_q == '0);
	assign found = |eq_vec;

	always_comb begin
		cmd.key    = in_key;
		cmd.ins_en = in_acc && (op == sst_pkg::OP_INSERT) && !full;
		cmd.del_en = in_acc && (op == sst_pkg::OP_DELETE) && found;
	end

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			logic                             l_gt;
			logic signed [sst_pkg::KEY_W-1:0] l_key;
			logic signed [sst_pkg::KEY_W-1:0] r_key;

			assign valid[gi]  = (sst_pkg::CNT_W'(gi) < count_q);
			assign eq_vec[gi] = flags[gi].eq;

			if (gi == 0) begin : g_first
				assign l_gt  = 1'b0;
				assign l_key = keys[gi];
			end else begin : g_mid
				assign l_gt  = flags[gi-1].gt;
				assign l_key = keys[gi-1];
			end

			if (gi == N - 1) begin : g_last
				assign r_key = keys[gi];
			end else begin : g_inner
				assign r_key = keys[gi+1];
			end

			sst_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.valid     (valid[gi]),
				.left_gt   (l_gt),
				.left_key  (l_key),
				.right_key (r_key),
				.key       (keys[gi]),
				.flags     (flags[gi])
			);
		end
	endgenerate

	always_comb begin
		count_d  = count_q;
		status_d = sst_pkg::ST_DONE;
		case (op)
			sst_pkg::OP_INSERT: begin
				if (full) begin
					status_d = sst_pkg::ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			sst_pkg::OP_DELETE: begin
				if (empty) begin
					status_d = sst_pkg::ST_EMPTY;
				end else if (!found) begin
					status_d = sst_pkg::ST_NOT_FOUND;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			sst_pkg::OP_SEARCH: begin
				if (!found) begin
					status_d = sst_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				status_d = sst_pkg::ST_DONE;
			end
		endcase
	end

	// report the low bits of the count in the result field
	assign count_wide = {{sst_pkg::ECNT_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q <= status_d;
			ecount_q <= count_wide[sst_pkg::ECNT_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, ecount_q, status_q};

	// ---------------------------------------------------------------- checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sst_pkg::CNT_W'(N))
		else $error("entry count above capacity");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(count_q))
		else $error("entry count changed without an accepted word");

	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_en |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the table");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && status_d == sst_pkg::ST_FULL |-> full && op == sst_pkg::OP_INSERT)
		else $error("full status without a full table");

	a_delete_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del_en |-> $countones(eq_vec) > 0 && !empty)
		else $error("delete shift without a match");

endmodule

@@ tb/sv/sorted_set_table_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_table_top_test
// Self-checking bench for the sorted set table.
// ----------------------------------------------------------------------------
// A directed opening covers the empty table, key extremes, duplicates, a
// full table and the unused opcode. Random bursts then alternate between
// filling and draining the table. Most keys are drawn from the keys already
// held or from a small pool, so hits and duplicates are common. Both stream
// sides idle at random. A scoreboard keeps its own sorted copy of the table
// and checks status and entry count of every result word in order.
// ----------------------------------------------------------------------------
module sorted_set_table_top_test;
	import sst_pkg::*;

	localparam int N_RANDOM   = 825;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_WAIT = 8;

	typedef struct packed {
		status_t             status;
		logic [ECNT_W-1:0]   entry_count;
	} table_result_t;

	class sorted_table_scoreboard;
		logic signed [KEY_W-1:0] held_keys[$];
		table_result_t           due_results[$];
		int                      mismatches;
		int                      words_in;
		int                      words_out;
		int                      full_hits;
		int                      empty_hits;
		int                      absent_hits;
		int                      dup_inserts;
		int                      peak_count;

		task report_mismatch(input string what);
			if (mismatches < 40)
				$display("mismatch at %0t: %s", $time, what);
			mismatches++;
		endtask

		// Update the table copy for one accepted word and queue its result.
		function void note_word(input op_t op, input logic signed [KEY_W-1:0] key);
			table_result_t res;
			int            pos;
			res.status = ST_DONE;
			pos = -1;
			words_in++;
			case (op)
				OP_INSERT: begin
					if (held_keys.size() >= CAPACITY) begin
						res.status = ST_FULL;
						full_hits++;
					end else begin
						pos = 0;
						while (pos < held_keys.size() && held_keys[pos] <= key) begin
							if (held_keys[pos] == key)
								dup_inserts++;
							pos++;
						end
						held_keys.insert(pos, key);
					end
				end
				OP_DELETE: begin
					if (held_keys.size() == 0) begin
						res.status = ST_EMPTY;
						empty_hits++;
					end else begin
						foreach (held_keys[i])
							if (pos < 0 && held_keys[i] == key)
								pos = i;
						if (pos < 0) begin
							res.status = ST_NOT_FOUND;
							absent_hits++;
						end else begin
							held_keys.delete(pos);
						end
					end
				end
				OP_SEARCH: begin
					res.status = ST_NOT_FOUND;
					foreach (held_keys[i])
						if (held_keys[i] == key)
							res.status = ST_DONE;
					if (res.status == ST_NOT_FOUND)
						absent_hits++;
				end
				default: ;
			endcase
			if (held_keys.size() > peak_count)
				peak_count = held_keys.size();
			res.entry_count = ECNT_W'(held_keys.size());
			due_results.push_back(res);
		endfunction

		task check_word(input logic [OUT_W-1:0] data);
			table_result_t want;
			status_t       got_status;
			logic [ECNT_W-1:0] got_count;
			got_status = status_t'(data[ST_W-1:0]);
			got_count  = data[ST_W +: ECNT_W];
			words_out++;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("unexpected word status=%0d count=%0d",
					got_status, got_count));
			end else begin
				want = due_results.pop_front();
				if (got_status != want.status)
					report_mismatch($sformatf("word %0d status %0d, want %0d",
						words_out, got_status, want.status));
				if (got_count != want.entry_count)
					report_mismatch($sformatf("word %0d entry_count %0d, want %0d",
						words_out, got_count, want.entry_count));
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;   // [1:0] opcode, [33:2] key, [39:34] zero
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;   // [1:0] status, [6:2] entry_count, [7] zero

	sorted_table_scoreboard table_sb = new();
	bit  calm;
	int  idle_cycles;

	sorted_set_table_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap();
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	task automatic send_word(input op_t op, input logic signed [KEY_W-1:0] key);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_W - KEY_W - OP_W){1'b0}}, key, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5 && table_sb.held_keys.size() > 0)
			return table_sb.held_keys[$urandom_range(0, table_sb.held_keys.size() - 1)];
		if (sel < 7)
			return KEY_W'($signed($urandom_range(0, 7)) - 4);
		if (sel == 7) begin
			case ($urandom_range(0, 3))
				0: return {1'b1, {(KEY_W-1){1'b0}}};
				1: return {1'b0, {(KEY_W-1){1'b1}}};
				2: return '1;
				default: return '0;
			endcase
		end
		return $urandom;
	endfunction

	// receiver: stall a random number of cycles before each word
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				table_sb.check_word(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				table_sb.note_word(op_t'(s_axis_tdata[OP_W-1:0]),
					s_axis_tdata[OP_W +: KEY_W]);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("stalled for %0d cycles, %0d results outstanding",
					idle_cycles, table_sb.due_results.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic signed [KEY_W-1:0] k_min;
		logic signed [KEY_W-1:0] k_max;
		bit  filling;
		int  r;
		op_t op;
		k_min = {1'b1, {(KEY_W-1){1'b0}}};
		k_max = {1'b0, {(KEY_W-1){1'b1}}};
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		calm          = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then fill it with extremes and duplicates
		send_word(OP_SEARCH, 5);
		send_word(OP_DELETE, 5);
		send_word(OP_NONE, 0);
		send_word(OP_INSERT, k_max);
		send_word(OP_INSERT, k_min);
		send_word(OP_INSERT, 0);
		send_word(OP_INSERT, -1);
		send_word(OP_INSERT, 7);
		send_word(OP_INSERT, 7);
		send_word(OP_INSERT, 7);
		send_word(OP_INSERT, -100);
		send_word(OP_INSERT, 100);
		for (int i = 1; i <= 6; i++)
			send_word(OP_INSERT, i);
		send_word(OP_INSERT, 8);
		// table is full now
		send_word(OP_INSERT, 9);
		send_word(OP_SEARCH, k_max);
		send_word(OP_SEARCH, 9999);
		send_word(OP_DELETE, 7);
		send_word(OP_DELETE, 12345);
		send_word(OP_NONE, k_min);

		// alternate drain and fill bursts, starting from a nearly full table
		filling = 1'b0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 40 == 0) begin
				filling = ~filling;
				calm    = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 2)
				op = OP_NONE;
			else if (filling)
				op = (r < 60) ? OP_INSERT : (r < 80) ? OP_DELETE : OP_SEARCH;
			else
				op = (r < 25) ? OP_INSERT : (r < 70) ? OP_DELETE : OP_SEARCH;
			send_word(op, pick_key());
		end
		s_axis_tvalid <= 1'b0;
		// let the scoreboard note the last accepted word first
		@(posedge clk);

		while (table_sb.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (table_sb.due_results.size() != 0)
			table_sb.report_mismatch("results still outstanding at end of run");

		$display("%0d words in, %0d results checked, peak count %0d",
			table_sb.words_in, table_sb.words_out, table_sb.peak_count);
		$display("full inserts %0d, empty deletes %0d, absent keys %0d, duplicates %0d",
			table_sb.full_hits, table_sb.empty_hits, table_sb.absent_hits,
			table_sb.dup_inserts);
		if (table_sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/sst_pkg.sv
rtl/sst_cell.sv
rtl/sorted_set_table_top.sv
tb/sv/sorted_set_table_top_test.sv
